>>> src/mips_ex_pkg.sv
// ----------------------------------------------------------------------------
// mips_ex_pkg
// shared types, constants and helpers of the mips subset executor
// ----------------------------------------------------------------------------
package mips_ex_pkg;

    localparam int unsigned DATA_WORDS = 65536;
    localparam int unsigned DATA_AW    = $clog2(DATA_WORDS);

    localparam logic [31:0] TEXT_BASE    = 32'h0040_0000;
    localparam logic [31:0] DATA_BASE    = 32'h1000_0000;
    localparam logic [31:0] GP_INIT      = 32'h1000_8000;
    localparam logic [31:0] SP_INIT      = DATA_BASE + 32'(DATA_WORDS * 4);
    localparam logic [31:0] PC_MSB_MASK  = 32'hf000_0000;
    localparam logic [24:0] PWORDS_RESET = 25'd0;

    // configuration register indexes
    localparam logic CFG_START_PC   = 1'b0;
    localparam logic CFG_PROG_WORDS = 1'b1;

    // opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_TRAP    = 6'h1a;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2b;

    // function codes
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_MFHI = 6'h10;
    localparam logic [5:0] FN_MFLO = 6'h12;
    localparam logic [5:0] FN_MULT = 6'h18;
    localparam logic [5:0] FN_DIV  = 6'h1a;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_SLT  = 6'h2a;

    // trap services
    localparam logic [3:0] SVC_NEWLINE = 4'h0;
    localparam logic [3:0] SVC_PRINT   = 4'h1;
    localparam logic [3:0] SVC_READ    = 4'h5;
    localparam logic [3:0] SVC_EXIT    = 4'ha;

    // print kinds
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_NEWLINE = 2'd1;
    localparam logic [1:0] KIND_PRINT   = 2'd2;
    localparam logic [1:0] KIND_READ    = 2'd3;

    // status codes
    localparam logic [2:0] ST_RUN       = 3'd0;
    localparam logic [2:0] ST_EXIT      = 3'd1;
    localparam logic [2:0] ST_DIVZERO   = 3'd2;
    localparam logic [2:0] ST_BAD_INSTR = 3'd3;
    localparam logic [2:0] ST_BAD_TRAP  = 3'd4;
    localparam logic [2:0] ST_UNALIGNED = 3'd5;
    localparam logic [2:0] ST_DATA_RNG  = 3'd6;
    localparam logic [2:0] ST_FETCH_RNG = 3'd7;

    localparam logic [4:0] REG_GP = 5'd28;
    localparam logic [4:0] REG_SP = 5'd29;
    localparam logic [4:0] REG_RA = 5'd31;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_LOAD,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic clr_en;
        logic accept;
        logic exec;
        logic div_step;
        logic load_wb;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic op_div;
        logic op_load;
        logic div_done;
        logic out_free;
    } t_dp_stat;

    // register value after reset
    function automatic logic [31:0] rf_init(input logic [4:0] idx);
        logic [31:0] v;
        v = 32'd0;
        if (idx == REG_GP) v = GP_INIT;
        if (idx == REG_SP) v = SP_INIT;
        return v;
    endfunction

endpackage

>>> src/mips_ex_ctrl.sv
// ----------------------------------------------------------------------------
// mips_ex_ctrl
// sequencer: memory clear, accept, execute, divide and load waits, push
// ----------------------------------------------------------------------------
module mips_ex_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  mips_ex_pkg::t_dp_stat i_stat,
    output mips_ex_pkg::t_dp_cmd  o_cmd
);

    mips_ex_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mips_ex_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mips_ex_pkg::S_CLEAR: begin
                if (i_stat.clr_done) n_state = mips_ex_pkg::S_IDLE;
            end
            mips_ex_pkg::S_IDLE: begin
                if (i_in_valid) n_state = mips_ex_pkg::S_EXEC;
            end
            mips_ex_pkg::S_EXEC: begin
                if (i_stat.op_div) n_state = mips_ex_pkg::S_DIV;
                else if (i_stat.op_load) n_state = mips_ex_pkg::S_LOAD;
                else n_state = mips_ex_pkg::S_PUSH;
            end
            mips_ex_pkg::S_DIV: begin
                if (i_stat.div_done) n_state = mips_ex_pkg::S_PUSH;
            end
            mips_ex_pkg::S_LOAD: begin
                n_state = mips_ex_pkg::S_PUSH;
            end
            mips_ex_pkg::S_PUSH: begin
                if (i_stat.out_free) n_state = mips_ex_pkg::S_IDLE;
            end
            default: n_state = mips_ex_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            mips_ex_pkg::S_CLEAR: o_cmd.clr_en = 1'b1;
            mips_ex_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            mips_ex_pkg::S_EXEC: o_cmd.exec     = 1'b1;
            mips_ex_pkg::S_DIV:  o_cmd.div_step = 1'b1;
            mips_ex_pkg::S_LOAD: o_cmd.load_wb  = 1'b1;
            mips_ex_pkg::S_PUSH: o_cmd.push     = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

>>> src/mips_ex_dp.sv
// ----------------------------------------------------------------------------
// mips_ex_dp
// architectural state, register file, data memory, divider and result regs
// ----------------------------------------------------------------------------
module mips_ex_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic [31:0]           i_instr_word,
    input  logic signed [31:0]    i_console_value,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [31:0]           o_next_pc,
    output logic [1:0]            o_print_kind,
    output logic signed [31:0]    o_print_value,
    output logic [2:0]            o_status,
    output logic [31:0]           o_executed_count,
    input  mips_ex_pkg::t_dp_cmd  i_cmd,
    output mips_ex_pkg::t_dp_stat o_stat
);

    localparam int unsigned AW = mips_ex_pkg::DATA_AW;

    // configuration and architectural state
    logic [24:0] r_prog_words;
    logic [31:0] r_pc, n_pc;
    logic [31:0] r_hi, r_lo;
    logic        r_halted, r_started;
    logic [2:0]  r_halt_st;
    logic [31:0] r_count;

    // item registers
    logic [31:0] r_instr, r_console, r_a, r_b;

    // register file
    logic [31:0] rf [32];
    logic [31:0] r_rf_vld;
    logic        rf_we;
    logic [4:0]  rf_wa;
    logic [31:0] rf_wd;

    // data memory
    logic [31:0]   dmem [mips_ex_pkg::DATA_WORDS];
    logic [AW-1:0] r_clr_idx;
    logic [31:0]   r_mem_q;
    logic          sw_we;
    logic [AW-1:0] mem_idx;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [31:0]   mem_wd;

    // divider
    logic [31:0] r_quo, r_rem, r_mb;
    logic        r_neg_q, r_neg_r;
    logic [4:0]  r_div_cnt;
    logic [32:0] rem_sh, rem_diff;
    logic [31:0] quo_nx, rem_nx;

    // result
    logic [1:0]  r_res_kind, x_kind;
    logic [31:0] r_res_pval, x_pval;
    logic [2:0]  r_res_st, x_st;
    logic        r_out_valid;

    // decode
    logic [5:0]  opcode, funct;
    logic [4:0]  rs, rt, rd, shamt;
    logic [31:0] uimm, simm, jtgt, pc4, addr, off;
    logic        fetch_bad, run, op_div, op_load, mul_we, div_go;
    logic signed [63:0] prod;

    assign opcode = r_instr[31:26];
    assign rs     = r_instr[25:21];
    assign rt     = r_instr[20:16];
    assign rd     = r_instr[15:11];
    assign shamt  = r_instr[10:6];
    assign funct  = r_instr[5:0];
    assign uimm   = {16'd0, r_instr[15:0]};
    assign simm   = {{16{r_instr[15]}}, r_instr[15:0]};
    assign pc4    = r_pc + 32'd4;
    assign jtgt   = (pc4 & mips_ex_pkg::PC_MSB_MASK) | {4'd0, r_instr[25:0], 2'b00};
    assign addr   = r_a + simm;
    assign off    = addr - mips_ex_pkg::DATA_BASE;
    assign mem_idx = off[AW+1:2];
    assign prod   = $signed(r_a) * $signed(r_b);

    logic [29:0] fetch_word;
    assign fetch_word = 30'((r_pc - mips_ex_pkg::TEXT_BASE) >> 2);
    assign fetch_bad  = fetch_word >= {5'd0, r_prog_words};
    assign run        = !r_halted && !fetch_bad;

    // execute decode
    always_comb begin
        n_pc    = pc4;
        x_kind  = mips_ex_pkg::KIND_NONE;
        x_pval  = 32'd0;
        x_st    = mips_ex_pkg::ST_RUN;
        rf_we   = 1'b0;
        rf_wa   = rd;
        rf_wd   = 32'd0;
        mul_we  = 1'b0;
        div_go  = 1'b0;
        sw_we   = 1'b0;
        op_load = 1'b0;
        case (opcode)
            mips_ex_pkg::OP_SPECIAL: begin
                case (funct)
                    mips_ex_pkg::FN_SLL: begin
                        rf_we = 1'b1;
                        rf_wd = r_b << shamt;
                    end
                    mips_ex_pkg::FN_SRA: begin
                        rf_we = 1'b1;
                        rf_wd = $signed(r_b) >>> shamt;
                    end
                    mips_ex_pkg::FN_JR:   n_pc = r_a;
                    mips_ex_pkg::FN_MFHI: begin
                        rf_we = 1'b1;
                        rf_wd = r_hi;
                    end
                    mips_ex_pkg::FN_MFLO: begin
                        rf_we = 1'b1;
                        rf_wd = r_lo;
                    end
                    mips_ex_pkg::FN_MULT: mul_we = 1'b1;
                    mips_ex_pkg::FN_DIV: begin
                        if (r_b == 32'd0) x_st = mips_ex_pkg::ST_DIVZERO;
                        else div_go = 1'b1;
                    end
                    mips_ex_pkg::FN_ADDU: begin
                        rf_we = 1'b1;
                        rf_wd = r_a + r_b;
                    end
                    mips_ex_pkg::FN_SUBU: begin
                        rf_we = 1'b1;
                        rf_wd = r_a - r_b;
                    end
                    mips_ex_pkg::FN_SLT: begin
                        rf_we = 1'b1;
                        rf_wd = {31'd0, $signed(r_a) < $signed(r_b)};
                    end
                    default: x_st = mips_ex_pkg::ST_BAD_INSTR;
                endcase
            end
            mips_ex_pkg::OP_J:   n_pc = jtgt;
            mips_ex_pkg::OP_JAL: begin
                n_pc  = jtgt;
                rf_we = 1'b1;
                rf_wa = mips_ex_pkg::REG_RA;
                rf_wd = pc4;
            end
            mips_ex_pkg::OP_BEQ: begin
                if (r_a == r_b) n_pc = pc4 + {simm[29:0], 2'b00};
            end
            mips_ex_pkg::OP_BNE: begin
                if (r_a != r_b) n_pc = pc4 + {simm[29:0], 2'b00};
            end
            mips_ex_pkg::OP_ADDIU: begin
                rf_we = 1'b1;
                rf_wa = rt;
                rf_wd = r_a + simm;
            end
            mips_ex_pkg::OP_ANDI: begin
                rf_we = 1'b1;
                rf_wa = rt;
                rf_wd = r_a & uimm;
            end
            mips_ex_pkg::OP_LUI: begin
                rf_we = 1'b1;
                rf_wa = rt;
                rf_wd = {r_instr[15:0], 16'd0};
            end
            mips_ex_pkg::OP_TRAP: begin
                case (r_instr[3:0])
                    mips_ex_pkg::SVC_NEWLINE: x_kind = mips_ex_pkg::KIND_NEWLINE;
                    mips_ex_pkg::SVC_PRINT: begin
                        x_kind = mips_ex_pkg::KIND_PRINT;
                        x_pval = r_a;
                    end
                    mips_ex_pkg::SVC_READ: begin
                        x_kind = mips_ex_pkg::KIND_READ;
                        rf_we  = 1'b1;
                        rf_wa  = rt;
                        rf_wd  = r_console;
                    end
                    mips_ex_pkg::SVC_EXIT: x_st = mips_ex_pkg::ST_EXIT;
                    default: x_st = mips_ex_pkg::ST_BAD_TRAP;
                endcase
            end
            mips_ex_pkg::OP_LW, mips_ex_pkg::OP_SW: begin
                if (addr[1:0] != 2'b00) x_st = mips_ex_pkg::ST_UNALIGNED;
                else if (off[31:2] >= 30'(mips_ex_pkg::DATA_WORDS))
                    x_st = mips_ex_pkg::ST_DATA_RNG;
                else if (opcode == mips_ex_pkg::OP_LW) op_load = 1'b1;
                else sw_we = 1'b1;
            end
            default: x_st = mips_ex_pkg::ST_BAD_INSTR;
        endcase
    end

    assign op_div = run && div_go;

    // config and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_words <= mips_ex_pkg::PWORDS_RESET;
            r_pc         <= mips_ex_pkg::TEXT_BASE;
            r_hi         <= 32'd0;
            r_lo         <= 32'd0;
            r_halted     <= 1'b0;
            r_started    <= 1'b0;
            r_halt_st    <= mips_ex_pkg::ST_RUN;
            r_count      <= 32'd0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == mips_ex_pkg::CFG_START_PC) begin
                    // entry point only matters until the first beat runs
                    if (!r_started) r_pc <= i_cfg_data;
                end else begin
                    r_prog_words <= i_cfg_data[24:0];
                end
            end
            if (i_cmd.exec && !r_halted) begin
                r_started <= 1'b1;
                if (fetch_bad) begin
                    r_halted  <= 1'b1;
                    r_halt_st <= mips_ex_pkg::ST_FETCH_RNG;
                end else begin
                    r_count <= r_count + 32'd1;
                    r_pc    <= n_pc;
                    if (x_st != mips_ex_pkg::ST_RUN) begin
                        r_halted  <= 1'b1;
                        r_halt_st <= x_st;
                    end
                    if (mul_we) begin
                        r_hi <= prod[63:32];
                        r_lo <= prod[31:0];
                    end
                end
            end
            if (i_cmd.div_step && r_div_cnt == 5'd31) begin
                r_lo <= r_neg_q ? 32'd0 - quo_nx : quo_nx;
                r_hi <= r_neg_r ? 32'd0 - rem_nx : rem_nx;
            end
        end
    end

    // item capture and register file read
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_instr   <= i_instr_word;
            r_console <= i_console_value;
            r_a <= r_rf_vld[i_instr_word[25:21]] ? rf[i_instr_word[25:21]]
                                                 : mips_ex_pkg::rf_init(i_instr_word[25:21]);
            r_b <= r_rf_vld[i_instr_word[20:16]] ? rf[i_instr_word[20:16]]
                                                 : mips_ex_pkg::rf_init(i_instr_word[20:16]);
        end
    end

    // register file write, r0 never written
    logic        wb_en;
    logic [4:0]  wb_a;
    logic [31:0] wb_d;
    assign wb_en = ((i_cmd.exec && run && rf_we && x_st == mips_ex_pkg::ST_RUN) ||
                    i_cmd.load_wb) && wb_a != 5'd0;
    assign wb_a  = i_cmd.load_wb ? rt : rf_wa;
    assign wb_d  = i_cmd.load_wb ? r_mem_q : rf_wd;

    always_ff @(posedge i_clk) begin
        if (wb_en) rf[wb_a] <= wb_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= 32'd0;
        end else if (wb_en) begin
            r_rf_vld[wb_a] <= 1'b1;
        end
    end

    // data memory with clearing pass after reset
    assign mem_we = i_cmd.clr_en || (i_cmd.exec && run && sw_we);
    assign mem_wa = i_cmd.clr_en ? r_clr_idx : mem_idx;
    assign mem_wd = i_cmd.clr_en ? 32'd0 : r_b;

    always_ff @(posedge i_clk) begin
        if (mem_we) dmem[mem_wa] <= mem_wd;
        r_mem_q <= dmem[mem_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_idx <= r_clr_idx + AW'(1);
        end
    end

    // restoring divider, one quotient bit a cycle
    assign rem_sh   = {r_rem, r_quo[31]};
    assign rem_diff = rem_sh - {1'b0, r_mb};
    assign rem_nx   = rem_diff[32] ? rem_sh[31:0] : rem_diff[31:0];
    assign quo_nx   = {r_quo[30:0], !rem_diff[32]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_quo     <= r_a[31] ? 32'd0 - r_a : r_a;
            r_mb      <= r_b[31] ? 32'd0 - r_b : r_b;
            r_rem     <= 32'd0;
            r_neg_q   <= r_a[31] ^ r_b[31];
            r_neg_r   <= r_a[31];
            r_div_cnt <= 5'd0;
        end else if (i_cmd.div_step) begin
            r_quo     <= quo_nx;
            r_rem     <= rem_nx;
            r_div_cnt <= r_div_cnt + 5'd1;
        end
    end

    // pending result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (r_halted) begin
                r_res_kind <= mips_ex_pkg::KIND_NONE;
                r_res_pval <= 32'd0;
                r_res_st   <= r_halt_st;
            end else if (fetch_bad) begin
                r_res_kind <= mips_ex_pkg::KIND_NONE;
                r_res_pval <= 32'd0;
                r_res_st   <= mips_ex_pkg::ST_FETCH_RNG;
            end else begin
                r_res_kind <= x_kind;
                r_res_pval <= x_pval;
                r_res_st   <= x_st;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            o_next_pc        <= r_pc;
            o_print_kind     <= r_res_kind;
            o_print_value    <= r_res_pval;
            o_status         <= r_res_st;
            o_executed_count <= r_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stat.clr_done = r_clr_idx == {AW{1'b1}};
    assign o_stat.op_div   = op_div;
    assign o_stat.op_load  = run && op_load;
    assign o_stat.div_done = r_div_cnt == 5'd31;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

endmodule

>>> src/mips_subset_instruction_executor_top.sv
// ----------------------------------------------------------------------------
// mips_subset_instruction_executor_top
// executes one mips32 subset instruction word per input beat
// ----------------------------------------------------------------------------
// after reset the block sweeps its 65536-word data memory to zero, one word a
// cycle, so o_in_ready stays low until the sweep ends (config writes are taken
// meanwhile). each input beat carries the word fetched at the last reported
// next_pc and yields exactly one output beat. an item passes through accept
// with register read, execute and push, plus a registered data memory read
// before the push for lw and restoring divider steps, one quotient bit a
// cycle, before the push for div. the next item is taken once the result
// sits in the output register, so a full output register stalls the push
// and the input with it. once an exit, an error or a fetch past
// program_words halts the core, every beat returns the held pc, status and
// count with no print.
// ----------------------------------------------------------------------------
module mips_subset_instruction_executor_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [31:0]        i_instr_word,
    input  logic signed [31:0] i_console_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_next_pc,
    output logic [1:0]         o_print_kind,
    output logic signed [31:0] o_print_value,
    output logic [2:0]         o_status,
    output logic [31:0]        o_executed_count
);

    mips_ex_pkg::t_dp_cmd  cmd;
    mips_ex_pkg::t_dp_stat stat;

    // sequencer
    mips_ex_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // state, memories and result register
    mips_ex_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_instr_word     (i_instr_word),
        .i_console_value  (i_console_value),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_next_pc        (o_next_pc),
        .o_print_kind     (o_print_kind),
        .o_print_value    (o_print_value),
        .o_status         (o_status),
        .o_executed_count (o_executed_count),
        .i_cmd            (cmd),
        .o_stat           (stat)
    );

    // one item in flight: no accept right after an accept
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("accept while an item is in flight");

    // print value only for a print beat
    a_pval_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_print_kind != mips_ex_pkg::KIND_PRINT) |-> o_print_value == 32'd0)
        else $error("print value without print kind");

    // halting beats never print
    a_halt_no_print: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != mips_ex_pkg::ST_RUN)
            |-> o_print_kind == mips_ex_pkg::KIND_NONE)
        else $error("print on a halting beat");

endmodule
